// ===== rtl/pfs_pkg.sv =====
// Shared constants, types and the reciprocal table of the pooling stream.
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_KERNEL     = 8;
    localparam int MAX_MAP_SIZE   = 64;
    localparam int KERNEL_BITS    = 4;
    localparam int MAP_BITS       = 7;
    localparam int POS_BITS       = 6;
    localparam int ACC_BITS       = SAMPLE_BITS + 2 * $clog2(MAX_KERNEL);
    localparam int KW             = $clog2(MAX_KERNEL);
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int OUT_DATA_BITS  = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RECIP_SHIFT    = 28;
    localparam int RECIP_BITS     = RECIP_SHIFT + 1;
    localparam int PROD_BITS      = ACC_BITS + RECIP_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_SIZE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_SIZE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_MODE   = 2'd2;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 4'd2;
    localparam logic [MAP_BITS-1:0]    MAP_RESET    = 7'd28;

    typedef struct packed {
        logic [POS_BITS-1:0]        pos;
        logic signed [ACC_BITS-1:0] acc;
    } entry_t;

    // ceil(2^RECIP_SHIFT / (k*k)), indexed by k-1
    function automatic logic [RECIP_BITS-1:0] recip(input logic [KW-1:0] kidx);
        logic [RECIP_BITS-1:0] r;
        case (kidx)
            3'd0:    r = 29'd268435456;
            3'd1:    r = 29'd67108864;
            3'd2:    r = 29'd29826162;
            3'd3:    r = 29'd16777216;
            3'd4:    r = 29'd10737419;
            3'd5:    r = 29'd7456541;
            3'd6:    r = 29'd5478275;
            default: r = 29'd4194304;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/pool_forward_stream.sv =====
// Top level of the streaming max / average pooling block.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  s       | in        | s_tvalid / s_tready  | s_tdata: sample
//  m       | out       | m_tvalid / m_tready  | m_tdata: pooled, max_position; m_tlast: map_done
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle while s_tready is high; the sample that closes a window passes the
// column RAM read, update and write back, divide multiplier and output buffer in turn.
// Column state lives in one RAM; back-to-back updates of a column use a bypass register.
// Reset and writes to registers 0-2 restart the map at row 0, column 0; no RAM clearing pass.
// s_tready drops only when a result is due and the two-entry output buffer is full.
`timescale 1ns / 1ps

module pool_forward_stream #(
    parameter int MAX_MAP_SIZE = pfs_pkg::MAX_MAP_SIZE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pfs_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [15:0] sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pfs_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // [15:0] pooled, [21:16] max_position
    output logic                                 m_tlast,   // map_done
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pfs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int CW  = $clog2(MAX_MAP_SIZE);
    localparam int MW  = $clog2(MAX_MAP_SIZE + 1);
    localparam int KW  = pfs_pkg::KW;
    localparam int SB  = pfs_pkg::SAMPLE_BITS;
    localparam int AB  = pfs_pkg::ACC_BITS;
    localparam int PB  = pfs_pkg::POS_BITS;
    localparam int KB  = pfs_pkg::KERNEL_BITS;
    localparam int RS  = pfs_pkg::RECIP_SHIFT;
    localparam int PRB = pfs_pkg::PROD_BITS;
    localparam int OB  = SB + PB;

    // configuration
    logic [KB-1:0]                kernel_reg;
    logic [pfs_pkg::MAP_BITS-1:0] map_reg;
    logic                         mode_reg;
    logic                         cfg_wr;

    // raster counters
    logic [CW-1:0] col_reg, row_reg, wcol_reg;
    logic [KW-1:0] wx_reg, wy_reg;

    logic [KB-1:0] k_eff;
    logic [KW-1:0] k_last;
    logic [MW-1:0] m_eff, m_last;
    logic          col_last, row_last, wx_last, wy_last;
    logic          accept, adv;

    // stage 1: RAM data back, update and write
    logic                  s1_v_reg, fwd_reg;
    logic                  s1_first_reg, s1_emit_reg, s1_done_reg, s1_mode_reg;
    logic [CW-1:0]         s1_addr_reg;
    logic [PB-1:0]         s1_pos_reg;
    logic [KW-1:0]         s1_kidx_reg;
    logic signed [SB-1:0]  s1_sample_reg;
    pfs_pkg::entry_t       wb_reg, rdata, base, upd;
    logic signed [AB-1:0]  sample_ext;

    // stage 2: magnitude and multiply
    logic                  s2_v_reg, s2_done_reg, s2_mode_reg;
    logic [KW-1:0]         s2_kidx_reg;
    pfs_pkg::entry_t       s2_ent_reg;
    logic                  s2_neg;
    logic [AB-1:0]         s2_mag;

    // stage 3: scale back and select
    logic                  s3_v_reg, s3_done_reg, s3_mode_reg, s3_neg_reg;
    logic [PRB-1:0]        s3_prod_reg;
    logic [SB-1:0]         s3_acc_reg;
    logic [PB-1:0]         s3_pos_reg;
    logic [SB-1:0]         quot, pooled_out;
    logic [PB-1:0]         pos_out;

    // output buffer
    logic [OB:0]           buf_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            cnt_reg;
    logic                  push, pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (kernel_reg == '0)
        begin
            k_eff = KB'(1);
        end
        else if (32'(kernel_reg) > pfs_pkg::MAX_KERNEL)
        begin
            k_eff = KB'(pfs_pkg::MAX_KERNEL);
        end
        else
        begin
            k_eff = kernel_reg;
        end
        if (map_reg == '0)
        begin
            m_eff = MW'(1);
        end
        else if (32'(map_reg) > MAX_MAP_SIZE)
        begin
            m_eff = MW'(MAX_MAP_SIZE);
        end
        else
        begin
            m_eff = MW'(map_reg);
        end
    end

    assign k_last   = KW'(k_eff - KB'(1));
    assign m_last   = m_eff - MW'(1);
    assign col_last = (MW'(col_reg) == m_last);
    assign row_last = (MW'(row_reg) == m_last);
    assign wx_last  = (wx_reg == k_last);
    assign wy_last  = (wy_reg == k_last);

    assign adv      = !s3_v_reg || (cnt_reg != 2'd2);
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    pfs_ram #(
        .WIDTH ($bits(pfs_pkg::entry_t)),
        .DEPTH (MAX_MAP_SIZE)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_v_reg && adv),
        .waddr (s1_addr_reg),
        .wdata (upd),
        .re    (accept),
        .raddr (wcol_reg),
        .rdata (rdata)
    );

    assign sample_ext = AB'(s1_sample_reg);

    always_comb
    begin
        if (s1_first_reg)
        begin
            base = '0;
        end
        else if (fwd_reg)
        begin
            base = wb_reg;
        end
        else
        begin
            base = rdata;
        end
        upd = base;
        if (s1_mode_reg == pfs_pkg::MODE_MAX)
        begin
            if (sample_ext > base.acc)
            begin
                upd.acc = sample_ext;
                upd.pos = s1_pos_reg;
            end
        end
        else
        begin
            upd.acc = base.acc + sample_ext;
        end
    end

    assign s2_neg = s2_ent_reg.acc[AB-1];
    assign s2_mag = s2_neg ? AB'(-s2_ent_reg.acc) : AB'(s2_ent_reg.acc);

    assign quot = SB'(s3_prod_reg >> RS);

    always_comb
    begin
        if (s3_mode_reg == pfs_pkg::MODE_AVG)
        begin
            pooled_out = s3_neg_reg ? SB'(-quot) : quot;
            pos_out    = '0;
        end
        else
        begin
            pooled_out = s3_acc_reg;
            pos_out    = s3_pos_reg;
        end
    end

    assign push = s3_v_reg && adv;
    assign pop  = m_tvalid && m_tready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = pfs_pkg::OUT_DATA_BITS'(buf_reg[rd_ptr_reg][OB-1:0]);
    assign m_tlast  = buf_reg[rd_ptr_reg][OB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= pfs_pkg::KERNEL_RESET;
            map_reg    <= pfs_pkg::MAP_RESET;
            mode_reg   <= pfs_pkg::MODE_MAX;
            col_reg    <= '0;
            row_reg    <= '0;
            wcol_reg   <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
            s1_v_reg   <= 1'b0;
            fwd_reg    <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    pfs_pkg::REG_KERNEL_SIZE: kernel_reg <= cfg_data[KB-1:0];
                    pfs_pkg::REG_MAP_SIZE:    map_reg    <= cfg_data;
                    pfs_pkg::REG_POOL_MODE:   mode_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_wr && (cfg_index == pfs_pkg::REG_KERNEL_SIZE ||
                           cfg_index == pfs_pkg::REG_MAP_SIZE ||
                           cfg_index == pfs_pkg::REG_POOL_MODE))
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                wcol_reg <= '0;
                wx_reg   <= '0;
                wy_reg   <= '0;
            end
            else if (accept)
            begin
                if (col_last)
                begin
                    col_reg  <= '0;
                    wx_reg   <= '0;
                    wcol_reg <= '0;
                    if (row_last)
                    begin
                        row_reg <= '0;
                        wy_reg  <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + CW'(1);
                        wy_reg  <= wy_last ? '0 : wy_reg + KW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                    if (wx_last)
                    begin
                        wx_reg   <= '0;
                        wcol_reg <= wcol_reg + CW'(1);
                    end
                    else
                    begin
                        wx_reg <= wx_reg + KW'(1);
                    end
                end
            end
            if (adv)
            begin
                fwd_reg  <= accept && s1_v_reg && (s1_addr_reg == wcol_reg);
                s1_v_reg <= accept;
                s2_v_reg <= s1_v_reg && s1_emit_reg;
                s3_v_reg <= s2_v_reg;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= SB'(s_tdata[SB-1:0]);
            s1_addr_reg   <= wcol_reg;
            s1_first_reg  <= (wx_reg == '0) && (wy_reg == '0);
            s1_emit_reg   <= (wy_last || row_last) && (wx_last || col_last);
            s1_done_reg   <= row_last && col_last;
            s1_mode_reg   <= mode_reg;
            s1_kidx_reg   <= k_last;
            s1_pos_reg    <= PB'(PB'(wy_reg) * PB'(k_eff) + PB'(wx_reg));
        end
        if (adv)
        begin
            if (s1_v_reg)
            begin
                wb_reg <= upd;
            end
            s2_ent_reg  <= upd;
            s2_done_reg <= s1_done_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_kidx_reg <= s1_kidx_reg;
            s3_prod_reg <= PRB'(s2_mag) * PRB'(pfs_pkg::recip(s2_kidx_reg));
            s3_neg_reg  <= s2_neg;
            s3_acc_reg  <= SB'(s2_ent_reg.acc);
            s3_pos_reg  <= s2_ent_reg.pos;
            s3_done_reg <= s2_done_reg;
            s3_mode_reg <= s2_mode_reg;
        end
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= {s3_done_reg, pos_out, pooled_out};
        end
    end

endmodule

// ===== rtl/pfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sim/pool_forward_stream_tb.sv =====
// Self-checking testbench: streams pooling maps under changing configuration, checks each window.
`timescale 1ns / 1ps

module pool_forward_stream_tb;

    localparam logic [pfs_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int IDLE_PCT      = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 10;
    localparam int N_DIRECTED    = 40;

    typedef struct packed {
        logic [pfs_pkg::SAMPLE_BITS-1:0] pooled;
        logic [pfs_pkg::POS_BITS-1:0]    pos;
        logic                            last;
    } pool_result_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [pfs_pkg::CFG_INDEX_BITS-1:0] index;
        logic [pfs_pkg::CFG_DATA_BITS-1:0]  value;
        logic [pfs_pkg::SAMPLE_BITS-1:0]    sample;
        logic                               typed;
        pool_result_t                       want;
    } stim_row_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [pfs_pkg::IN_DATA_BITS-1:0]      s_tdata = '0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [pfs_pkg::OUT_DATA_BITS-1:0]     m_tdata;
    logic                                  m_tlast;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [pfs_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [pfs_pkg::CFG_DATA_BITS-1:0]     cfg_data = '0;

    logic [pfs_pkg::KERNEL_BITS-1:0]       mdl_kernel;
    logic [pfs_pkg::MAP_BITS-1:0]          mdl_map;
    logic                                  mdl_mode;
    logic signed [pfs_pkg::ACC_BITS-1:0]   col_acc [pfs_pkg::MAX_MAP_SIZE];
    logic [pfs_pkg::POS_BITS-1:0]          col_best [pfs_pkg::MAX_MAP_SIZE];
    logic [pfs_pkg::POS_BITS-1:0]          row_cnt;
    logic [pfs_pkg::POS_BITS-1:0]          col_cnt;

    pool_result_t                 pending_pools [$];
    int                           errors = 0;
    bit                           quiet;
    bit                           hold_start;
    bit                           hold_done;

    stim_row_t directed [N_DIRECTED] = '{
        '{ROW_CFG,    pfs_pkg::REG_KERNEL_SIZE, 7'd1, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_MAP_SIZE,    7'd1, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_POOL_MODE,   7'(pfs_pkg::MODE_MAX), 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h7FFF, 1'b1, '{16'h7FFF, 6'd0, 1'b1}},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b1, '{16'h0000, 6'd0, 1'b1}},
        '{ROW_CFG,    pfs_pkg::REG_POOL_MODE,   7'(pfs_pkg::MODE_AVG), 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b1, '{16'h8000, 6'd0, 1'b1}},
        '{ROW_CFG,    pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'hFFFD, 1'b1, '{16'hFFFD, 6'd0, 1'b1}},
        '{ROW_CFG,    pfs_pkg::REG_KERNEL_SIZE, 7'd9, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_MAP_SIZE,    7'd0, 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h7FFF, 1'b1, '{16'h01FF, 6'd0, 1'b1}},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b1, '{16'hFE00, 6'd0, 1'b1}},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'hFFFF, 1'b1, '{16'h0000, 6'd0, 1'b1}},
        '{ROW_CFG,    pfs_pkg::REG_KERNEL_SIZE, 7'd1, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_MAP_SIZE,    7'd127, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_POOL_MODE,   7'(pfs_pkg::MODE_MAX), 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h1234, 1'b1, '{16'h1234, 6'd0, 1'b0}},
        '{ROW_CFG,    pfs_pkg::REG_KERNEL_SIZE, 7'd2, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_MAP_SIZE,    7'd3, 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0010, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0005, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0020, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0030, 1'b0, '0},
        '{ROW_CFG,    REG_UNUSED,               7'h7F, 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'hFFF0, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h7FFF, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0001, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8001, 1'b0, '0},
        '{ROW_CFG,    pfs_pkg::REG_POOL_MODE,   7'(pfs_pkg::MODE_AVG), 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h7FFF, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0003, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'hFFFE, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h7FFF, 1'b0, '0},
        '{ROW_SAMPLE, pfs_pkg::REG_KERNEL_SIZE, 7'd0, 16'h0002, 1'b0, '0}
    };

    pool_forward_stream u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int kernel_eff(input logic [pfs_pkg::KERNEL_BITS-1:0] k);
        if (k == 0)
            return 1;
        if (k > pfs_pkg::MAX_KERNEL)
            return pfs_pkg::MAX_KERNEL;
        return int'(k);
    endfunction

    function automatic int map_eff(input logic [pfs_pkg::MAP_BITS-1:0] m);
        if (m == 0)
            return 1;
        if (m > pfs_pkg::MAX_MAP_SIZE)
            return pfs_pkg::MAX_MAP_SIZE;
        return int'(m);
    endfunction

    function automatic logic [pfs_pkg::SAMPLE_BITS-1:0] draw_sample();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            case ($urandom_range(3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 45)
            return pfs_pkg::SAMPLE_BITS'($urandom_range(1023) - 512);
        return pfs_pkg::SAMPLE_BITS'($urandom);
    endfunction

    task automatic restart_pool_state();
        for (int i = 0; i < pfs_pkg::MAX_MAP_SIZE; i++)
        begin
            col_acc[i]  = '0;
            col_best[i] = '0;
        end
        row_cnt = '0;
        col_cnt = '0;
    endtask

    task automatic model_reg_write(input logic [pfs_pkg::CFG_INDEX_BITS-1:0] idx,
                                   input logic [pfs_pkg::CFG_DATA_BITS-1:0] val);
        case (idx)
            pfs_pkg::REG_KERNEL_SIZE: mdl_kernel = val[pfs_pkg::KERNEL_BITS-1:0];
            pfs_pkg::REG_MAP_SIZE:    mdl_map    = val[pfs_pkg::MAP_BITS-1:0];
            pfs_pkg::REG_POOL_MODE:   mdl_mode   = val[0];
            default:                  return;
        endcase
        restart_pool_state();
    endtask

    task automatic pool_predict(input logic [pfs_pkg::SAMPLE_BITS-1:0] raw, output bit emit,
                                output pool_result_t res);
        int k, m, row, col, wy, wx, wcol, q;
        logic signed [pfs_pkg::SAMPLE_BITS-1:0] s;
        k    = kernel_eff(mdl_kernel);
        m    = map_eff(mdl_map);
        s    = raw;
        row  = int'(row_cnt) % m;
        col  = int'(col_cnt) % m;
        wy   = row % k;
        wx   = col % k;
        wcol = col / k;
        if (wy == 0 && wx == 0)
        begin
            col_acc[wcol]  = '0;
            col_best[wcol] = '0;
        end
        if (mdl_mode == pfs_pkg::MODE_MAX)
        begin
            if (s > col_acc[wcol])
            begin
                col_acc[wcol]  = s;
                col_best[wcol] = pfs_pkg::POS_BITS'(wy * k + wx);
            end
        end
        else
            col_acc[wcol] = col_acc[wcol] + s;
        emit = (wy == k - 1 || row == m - 1) && (wx == k - 1 || col == m - 1);
        res  = '0;
        if (emit)
        begin
            if (mdl_mode == pfs_pkg::MODE_MAX)
            begin
                res.pooled = col_acc[wcol][pfs_pkg::SAMPLE_BITS-1:0];
                res.pos    = col_best[wcol];
            end
            else
            begin
                q          = int'(col_acc[wcol]) / (k * k);
                res.pooled = q[pfs_pkg::SAMPLE_BITS-1:0];
            end
            res.last = (row == m - 1 && col == m - 1);
        end
        col++;
        if (col >= m)
        begin
            col = 0;
            row++;
            if (row >= m)
                row = 0;
        end
        row_cnt = pfs_pkg::POS_BITS'(row);
        col_cnt = pfs_pkg::POS_BITS'(col);
    endtask

    task automatic log_mismatch(input string what, input pool_result_t want,
                                input pool_result_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t %s: expected pooled=%h pos=%0d last=%b, got pooled=%h pos=%0d last=%b",
                     $time, what, want.pooled, want.pos, want.last,
                     got.pooled, got.pos, got.last);
    endtask

    task automatic send_sample(input logic [pfs_pkg::SAMPLE_BITS-1:0] v, input bit typed,
                               input pool_result_t want);
        bit emit;
        pool_result_t res;
        cfg_valid = 1'b0;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            s_tdata  = pfs_pkg::SAMPLE_BITS'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pool_predict(v, emit, res);
        if (typed)
            pending_pools.push_back(want);
        else if (emit)
            pending_pools.push_back(res);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        while (pending_pools.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pfs_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [pfs_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_reg_write(idx, val);
        @(negedge clk);
    endtask

    // hold off the output for a long stretch once requested, else stall at random outside the quiet phase
    initial
    begin : result_sink
        int left;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left > 0)
            begin
                m_tready = 1'b0;
                left--;
                if (left == 0)
                    hold_done = 1'b1;
            end
            else if (hold_start && !hold_done)
            begin
                m_tready = 1'b0;
                left     = HOLD_CYCLES;
            end
            else
                m_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_results
        pool_result_t got;
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pooled = m_tdata[pfs_pkg::SAMPLE_BITS-1:0];
            got.pos    = m_tdata[pfs_pkg::SAMPLE_BITS +: pfs_pkg::POS_BITS];
            got.last   = m_tlast;
            if (pending_pools.size() == 0)
                log_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_pools.pop_front();
                if (got.pooled !== want.pooled || got.pos !== want.pos ||
                    got.last !== want.last)
                    log_mismatch("mismatch", want, got);
            end
        end
    end

    initial
    begin : stimulus
        int phase, sent, n, k, m, ke, me, full, w;
        logic mode;
        mdl_kernel = pfs_pkg::KERNEL_RESET;
        mdl_map    = pfs_pkg::MAP_RESET;
        mdl_mode   = pfs_pkg::MODE_MAX;
        restart_pool_state();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(directed[r].index, directed[r].value);
            end
            else
                send_sample(directed[r].sample, directed[r].typed, directed[r].want);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            quiet = (phase == 2);
            case (phase)
                0:
                begin
                    k    = pfs_pkg::MAX_KERNEL;
                    m    = pfs_pkg::MAX_MAP_SIZE;
                    mode = pfs_pkg::MODE_AVG;
                end
                1:
                begin
                    k    = 1;
                    m    = 16;
                    mode = pfs_pkg::MODE_MAX;
                end
                2:
                begin
                    k    = $urandom_range(1, pfs_pkg::MAX_KERNEL);
                    m    = 16;
                    mode = 1'($urandom_range(1));
                end
                default:
                begin
                    k    = ($urandom_range(4) == 0) ? $urandom_range(15)
                                                    : $urandom_range(1, pfs_pkg::MAX_KERNEL);
                    w    = $urandom_range(9);
                    m    = (w < 7) ? $urandom_range(1, 12) :
                           (w < 9) ? $urandom_range(13, 40) : $urandom_range(41, 127);
                    mode = 1'($urandom_range(1));
                end
            endcase
            write_reg(pfs_pkg::REG_KERNEL_SIZE, pfs_pkg::CFG_DATA_BITS'(k));
            write_reg(pfs_pkg::REG_MAP_SIZE, pfs_pkg::CFG_DATA_BITS'(m));
            write_reg(pfs_pkg::REG_POOL_MODE, pfs_pkg::CFG_DATA_BITS'(mode));
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, pfs_pkg::CFG_DATA_BITS'($urandom_range(127)));

            ke   = kernel_eff(pfs_pkg::KERNEL_BITS'(k));
            me   = map_eff(pfs_pkg::MAP_BITS'(m));
            full = me * me;
            if (phase == 0)
                n = me * ke + me;
            else if (phase == 1 || phase == 2)
                n = full;
            else if (full <= 256)
                n = full * $urandom_range(1, 2) + $urandom_range(0, full - 1);
            else
                n = me * ke + $urandom_range(1, me);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            if (phase == 1)
                hold_start = 1'b1;
            for (int i = 0; i < n; i++)
                send_sample(draw_sample(), 1'b0, '0);
            sent += n;
            phase++;
        end

        s_tvalid = 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_pools.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        errors += pending_pools.size();
        if (errors == 0)
            $display("pool_forward_stream_tb OK");
        else
            $display("pool_forward_stream_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("pool_forward_stream_tb NOT OK");
        $finish;
    end

endmodule
